// ===== sv/json_token_lexer_core_macros.svh =====
// Assertion helpers shared by the lexer modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef JSON_TOKEN_LEXER_CORE_MACROS_SVH
`define JSON_TOKEN_LEXER_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define JTL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define JTL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/jtl_pkg.sv =====
`timescale 1ns / 1ps

package jtl_pkg;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_STRING = 5'b00010,
        MODE_NUMBER = 5'b00100,
        MODE_WORD   = 5'b01000,
        MODE_HALTED = 5'b10000
    } mode_t;

    typedef logic [3:0] kind_t;

    localparam kind_t KIND_OBJ_OPEN = 4'd0;
    localparam kind_t KIND_OBJ_CLOSE = 4'd1;
    localparam kind_t KIND_ARR_OPEN = 4'd2;
    localparam kind_t KIND_ARR_CLOSE = 4'd3;
    localparam kind_t KIND_COLON = 4'd4;
    localparam kind_t KIND_COMMA = 4'd5;
    localparam kind_t KIND_STRING = 4'd6;
    localparam kind_t KIND_NUMBER = 4'd7;
    localparam kind_t KIND_BOOLEAN = 4'd8;
    localparam kind_t KIND_NULL = 4'd9;
    localparam kind_t KIND_EOF = 4'd10;
    localparam kind_t KIND_BAD_WORD = 4'd11;
    localparam kind_t KIND_BAD_BYTE = 4'd12;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT = 8'h2E;

    // Words are packed with their first letter in the low byte.
    localparam logic [39:0] WORD_TRUE = 40'h0065757274;
    localparam logic [39:0] WORD_FALSE = 40'h65736C6166;
    localparam logic [39:0] WORD_NULL = 40'h006C6C756E;
    localparam logic [2:0] WORD_LEN_MAX = 3'd5;

    typedef struct packed {
        kind_t      token_kind;
        logic [7:0] text_byte;
        logic       has_byte;
        logic       token_done;
        logic       bool_value;
        logic       last_result;
    } rec_t;

    // Records produced for one accepted byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        rec_t       rec0;
        rec_t       rec1;
    } step_t;

endpackage

// ===== sv/jtl_if.sv =====
`timescale 1ns / 1ps

interface jtl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_text;

    modport source (output valid, output byte_value, output end_of_text, input ready);
    modport sink (input valid, input byte_value, input end_of_text, output ready);
endinterface

interface jtl_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       token_done;
    logic       bool_value;
    logic       last_result;

    modport source (
        output valid, output token_kind, output text_byte, output has_byte,
        output token_done, output bool_value, output last_result, input ready
    );
    modport sink (
        input valid, input token_kind, input text_byte, input has_byte,
        input token_done, input bool_value, input last_result, output ready
    );
endinterface

// ===== sv/jtl_engine.sv =====
`timescale 1ns / 1ps
`include "json_token_lexer_core_macros.svh"

module jtl_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    byte_value,
    input  logic          end_of_text,
    output jtl_pkg::step_t step
);
    import jtl_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [39:0] word_reg, word_next;
    logic [2:0]  len_reg, len_next;

    logic        eot;
    logic        is_space, is_digit, is_letter;
    logic        idle_valid, idle_letter;
    rec_t        idle_rec;
    mode_t       idle_mode;
    logic        word_ok;
    rec_t        word_rec;
    logic        first_valid, second_valid;
    rec_t        first_rec, second_rec;

    function automatic rec_t mk_rec(kind_t kind, logic [7:0] b, logic has, logic done,
                                    logic bv);
        rec_t r;
        r.token_kind = kind;
        r.text_byte = b;
        r.has_byte = has;
        r.token_done = done;
        r.bool_value = bv;
        r.last_result = 1'b0;
        return r;
    endfunction

    assign eot = end_of_text || (byte_value == 8'h00);
    assign is_space = (byte_value == 8'h20) || (byte_value inside {[8'h09:8'h0D]});
    assign is_digit = byte_value inside {[8'h30:8'h39]};
    assign is_letter = byte_value inside {[8'h41:8'h5A], [8'h61:8'h7A]};

    // Lexing of the byte as if no token were open.
    always_comb
    begin
        idle_valid = 1'b0;
        idle_letter = 1'b0;
        idle_mode = MODE_IDLE;
        idle_rec = mk_rec(KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b0);
        if (!is_space)
        begin
            case (byte_value)
                CH_LBRACE:
                begin
                    idle_valid = 1'b1;
                    idle_rec = mk_rec(KIND_OBJ_OPEN, 8'h00, 1'b0, 1'b1, 1'b0);
                end
                CH_RBRACE:
                begin
                    idle_valid = 1'b1;
                    idle_rec = mk_rec(KIND_OBJ_CLOSE, 8'h00, 1'b0, 1'b1, 1'b0);
                end
                CH_LBRACKET:
                begin
                    idle_valid = 1'b1;
                    idle_rec = mk_rec(KIND_ARR_OPEN, 8'h00, 1'b0, 1'b1, 1'b0);
                end
                CH_RBRACKET:
                begin
                    idle_valid = 1'b1;
                    idle_rec = mk_rec(KIND_ARR_CLOSE, 8'h00, 1'b0, 1'b1, 1'b0);
                end
                CH_COLON:
                begin
                    idle_valid = 1'b1;
                    idle_rec = mk_rec(KIND_COLON, 8'h00, 1'b0, 1'b1, 1'b0);
                end
                CH_COMMA:
                begin
                    idle_valid = 1'b1;
                    idle_rec = mk_rec(KIND_COMMA, 8'h00, 1'b0, 1'b1, 1'b0);
                end
                CH_QUOTE:
                begin
                    idle_mode = MODE_STRING;
                end
                default:
                begin
                    if (is_digit || (byte_value == CH_MINUS))
                    begin
                        idle_valid = 1'b1;
                        idle_mode = MODE_NUMBER;
                        idle_rec = mk_rec(KIND_NUMBER, byte_value, 1'b1, 1'b0, 1'b0);
                    end
                    else if (is_letter)
                    begin
                        idle_letter = 1'b1;
                        idle_mode = MODE_WORD;
                    end
                    else
                    begin
                        idle_valid = 1'b1;
                        idle_mode = MODE_HALTED;
                        idle_rec = mk_rec(KIND_BAD_BYTE, 8'h00, 1'b0, 1'b1, 1'b0);
                    end
                end
            endcase
        end
    end

    // Record for the buffered word when it ends.
    always_comb
    begin
        word_ok = 1'b1;
        if ((len_reg == 3'd4) && (word_reg == WORD_TRUE))
        begin
            word_rec = mk_rec(KIND_BOOLEAN, 8'h00, 1'b0, 1'b1, 1'b1);
        end
        else if ((len_reg == WORD_LEN_MAX) && (word_reg == WORD_FALSE))
        begin
            word_rec = mk_rec(KIND_BOOLEAN, 8'h00, 1'b0, 1'b1, 1'b0);
        end
        else if ((len_reg == 3'd4) && (word_reg == WORD_NULL))
        begin
            word_rec = mk_rec(KIND_NULL, 8'h00, 1'b0, 1'b1, 1'b0);
        end
        else
        begin
            word_ok = 1'b0;
            word_rec = mk_rec(KIND_BAD_WORD, 8'h00, 1'b0, 1'b1, 1'b0);
        end
    end

    always_comb
    begin
        first_valid = 1'b0;
        first_rec = idle_rec;
        second_valid = 1'b0;
        second_rec = idle_rec;
        mode_next = mode_reg;
        word_next = word_reg;
        len_next = len_reg;
        if (eot)
        begin
            case (mode_reg)
                MODE_STRING:
                begin
                    first_valid = 1'b1;
                    first_rec = mk_rec(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0);
                end
                MODE_NUMBER:
                begin
                    first_valid = 1'b1;
                    first_rec = mk_rec(KIND_NUMBER, 8'h00, 1'b0, 1'b1, 1'b0);
                end
                MODE_WORD:
                begin
                    first_valid = 1'b1;
                    first_rec = word_rec;
                end
                default:
                begin
                    first_valid = 1'b0;
                end
            endcase
            second_valid = 1'b1;
            second_rec = mk_rec(KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b0);
            mode_next = MODE_IDLE;
            word_next = '0;
            len_next = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_HALTED:
                begin
                    mode_next = MODE_HALTED;
                end
                MODE_STRING:
                begin
                    first_valid = 1'b1;
                    if (byte_value == CH_QUOTE)
                    begin
                        first_rec = mk_rec(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        first_rec = mk_rec(KIND_STRING, byte_value, 1'b1, 1'b0, 1'b0);
                    end
                end
                MODE_NUMBER:
                begin
                    first_valid = 1'b1;
                    if (is_digit || (byte_value == CH_DOT) || (byte_value == CH_MINUS))
                    begin
                        first_rec = mk_rec(KIND_NUMBER, byte_value, 1'b1, 1'b0, 1'b0);
                    end
                    else
                    begin
                        first_rec = mk_rec(KIND_NUMBER, 8'h00, 1'b0, 1'b1, 1'b0);
                        second_valid = idle_valid;
                        mode_next = idle_mode;
                        if (idle_letter)
                        begin
                            word_next = {32'h0, byte_value};
                            len_next = 3'd1;
                        end
                    end
                end
                MODE_WORD:
                begin
                    if (is_letter)
                    begin
                        if (len_reg < WORD_LEN_MAX)
                        begin
                            word_next = word_reg | ({32'h0, byte_value} << {len_reg, 3'b000});
                            len_next = len_reg + 3'd1;
                        end
                        else
                        begin
                            first_valid = 1'b1;
                            first_rec = mk_rec(KIND_BAD_WORD, 8'h00, 1'b0, 1'b1, 1'b0);
                            word_next = '0;
                            len_next = '0;
                            mode_next = MODE_HALTED;
                        end
                    end
                    else
                    begin
                        first_valid = 1'b1;
                        first_rec = word_rec;
                        word_next = '0;
                        len_next = '0;
                        if (word_ok)
                        begin
                            second_valid = idle_valid;
                            mode_next = idle_mode;
                            if (idle_letter)
                            begin
                                word_next = {32'h0, byte_value};
                                len_next = 3'd1;
                            end
                        end
                        else
                        begin
                            mode_next = MODE_HALTED;
                        end
                    end
                end
                default:
                begin
                    second_valid = idle_valid;
                    mode_next = idle_mode;
                    if (idle_letter)
                    begin
                        word_next = {32'h0, byte_value};
                        len_next = 3'd1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        step.count = {1'b0, first_valid} + {1'b0, second_valid};
        step.rec0 = first_valid ? first_rec : second_rec;
        step.rec1 = second_rec;
        if (first_valid && second_valid)
        begin
            step.rec1.last_result = 1'b1;
        end
        else
        begin
            step.rec0.last_result = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            word_reg <= '0;
            len_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            word_reg <= word_next;
            len_reg <= len_next;
        end
    end

    `JTL_ASSERT(a_len_bound, len_reg <= WORD_LEN_MAX, "word length beyond five letters")
    `JTL_ASSERT(a_halt_silent, !(fire && !eot && (mode_reg == MODE_HALTED)) || (step.count == 2'd0), "halted lexer produced a record")
    `JTL_ASSERT(a_eot_last, !(fire && eot) || ((step.count == 2'd1) && (step.rec0.token_kind == KIND_EOF)) || ((step.count == 2'd2) && (step.rec1.token_kind == KIND_EOF)), "end of text without closing eof record")
    `JTL_ASSERT_NEXT(a_eot_idle, fire && eot, (mode_reg == MODE_IDLE) && (len_reg == 3'd0) && (word_reg == 40'h0), "lexer not idle after end of text")

endmodule

// ===== sv/json_token_lexer_core.sv =====
// JSON token lexer.
// The text channel takes one request per cycle while it is ready: a text
// byte, or the end of the text (end_of_text high, or a zero byte). The token
// channel gives zero, one or two token records per request, in text order.
// A byte is lexed in the cycle it is accepted, and its records enter a small
// record queue; if the queue was empty, the first one is offered on the
// token channel in the next cycle.
// Throughput is one byte per cycle while the queue has room. A byte that
// closes a number or a word and itself gives a record, or the end of text
// inside an open token, gives two records, offered one after the other.
// The text channel is ready while the queue has room for two records, so a
// stalled receiver lets FIFO_DEPTH - 1 or FIFO_DEPTH records build up before
// the text channel stops; no record is lost or repeated.
// Reset empties the queue and puts the lexer between tokens with an empty
// word buffer. An unknown byte or word halts the lexer; later bytes give no
// records until the end of text, which gives an eof record and resumes.
`timescale 1ns / 1ps
`include "json_token_lexer_core_macros.svh"

module json_token_lexer_core #(
    parameter int FIFO_DEPTH = 4
) (
    input logic      clk,
    input logic      rst_n,
    jtl_in_if.sink   text,
    jtl_out_if.source tokens
);
    import jtl_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(FIFO_DEPTH - 2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    rec_t             queue_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_second;
    logic             fire;
    logic             pop;
    step_t            step;
    rec_t             head;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign text.ready = (count_reg <= CNT_ROOM);
    assign fire = text.valid && text.ready;
    assign pop = tokens.valid && tokens.ready;

    jtl_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .byte_value  (text.byte_value),
        .end_of_text (text.end_of_text),
        .step        (step)
    );

    assign wr_ptr_second = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (fire && (step.count == 2'd1))
        begin
            wr_ptr_next = wr_ptr_second;
        end
        else if (fire && (step.count == 2'd2))
        begin
            wr_ptr_next = ptr_inc(wr_ptr_second);
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next = count_reg + (fire ? CNT_W'(step.count) : '0) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (fire && (step.count != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= step.rec0;
        end
        if (fire && (step.count == 2'd2))
        begin
            queue_reg[wr_ptr_second] <= step.rec1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    assign head = queue_reg[rd_ptr_reg];
    assign tokens.valid = (count_reg != '0);
    assign tokens.token_kind = head.token_kind;
    assign tokens.text_byte = head.text_byte;
    assign tokens.has_byte = head.has_byte;
    assign tokens.token_done = head.token_done;
    assign tokens.bool_value = head.bool_value;
    assign tokens.last_result = head.last_result;

    `JTL_ASSERT(a_queue_bound, count_reg <= CNT_FULL, "record queue overflow")
    `JTL_ASSERT_NEXT(a_push_count, fire && !pop && (step.count == 2'd2), count_reg == $past(count_reg) + CNT_W'(2), "record queue count lost a push")
    `JTL_ASSERT_NEXT(a_head_hold, tokens.valid && !pop, $stable(head), "stalled record changed")

endmodule
